### hw/rtl/abpw_pkg.sv
// shared constants, types and helpers for the alpha blend pixel writer
package abpw_pkg;

    localparam int MAX_WIDTH   = 64;
    localparam int MAX_HEIGHT  = 64;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int X_IDX_W     = $clog2(MAX_WIDTH);
    localparam int Y_IDX_W     = $clog2(MAX_HEIGHT);
    localparam int CFG_W       = 7;
    localparam int CFG_INDEX_W = 2;
    localparam int COORD_W     = 16;
    localparam int PIXEL_W     = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = CFG_INDEX_W'(1);

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(64);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(64);
    localparam logic [CFG_W-1:0] WIDTH_LIMIT  = CFG_W'(MAX_WIDTH);
    localparam logic [CFG_W-1:0] HEIGHT_LIMIT = CFG_W'(MAX_HEIGHT);

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

    typedef enum logic [1:0] {
        WS_OPAQUE      = 2'd0,
        WS_BLENDED     = 2'd1,
        WS_TRANSPARENT = 2'd2,
        WS_CLIPPED     = 2'd3
    } write_status_t;

    typedef struct packed {
        logic load;
        logic calc;
        logic mul;
        logic write;
        logic clear;
    } dp_cmd_t;

    typedef struct packed {
        logic clip;
        logic clear_last;
    } dp_status_t;

    // floor(v / 255) for v up to 255 * 255
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [16:0] t;
        t = {1'b0, v} + 17'd1 + {9'd0, v[15:8]};
        return t[15:8];
    endfunction

endpackage

### hw/rtl/alpha_blend_pixel_writer_top.sv
// top level of the alpha blend pixel writer
//
// usage: each request on the s_ channel carries a signed x, a signed upward y
// and an ARGB colour. the row is flipped to screen_height - y and clipped
// against the active width and height; alpha 255 overwrites, alpha 0 leaves
// the word alone, any other alpha blends red, green and blue and keeps the
// larger alpha. every request gives exactly one result on the m_ channel:
// status, word address and the stored word after the write.
// the config port writes screen_width (index 0) and screen_height (index 1)
// at any edge with cfg_we high; change them only while the block is idle.
// timing: a request is taken in the idle state and passes through the calc,
// read, mul and write states, a clipped request skipping mul; the result
// register is loaded in write. the steps come from the address multiply, the
// registered read of the frame store and the registered blend products.
// reset: the 4096-word frame store is swept to zero, one word a cycle, for
// 4096 cycles after reset, with s_ready held low meanwhile.
// stall: the result sits in an output register; the next request can be
// taken and worked on while it waits, and is held before its write until
// the receiver takes the earlier result.
module alpha_blend_pixel_writer_top
    import abpw_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]          cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [COORD_W-1:0] s_pos_x,
    input  logic signed [COORD_W-1:0] s_pos_y,
    input  logic [PIXEL_W-1:0]        s_src_colour,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_write_status,
    output logic [ADDR_W-1:0]         m_pixel_address,
    output logic [PIXEL_W-1:0]        m_pixel_value
);

    dp_cmd_t    cmd;
    dp_status_t status;

    abpw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    abpw_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_pos_x         (s_pos_x),
        .s_pos_y         (s_pos_y),
        .s_src_colour    (s_src_colour),
        .cmd             (cmd),
        .status          (status),
        .m_write_status  (m_write_status),
        .m_pixel_address (m_pixel_address),
        .m_pixel_value   (m_pixel_value)
    );

endmodule

### hw/rtl/abpw_datapath.sv
// datapath: config registers, address and clip unit, blend unit, frame store
module abpw_datapath
    import abpw_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]         cfg_wdata,
    input  logic signed [COORD_W-1:0] s_pos_x,
    input  logic signed [COORD_W-1:0] s_pos_y,
    input  logic [PIXEL_W-1:0]       s_src_colour,
    input  dp_cmd_t                  cmd,
    output dp_status_t               status,
    output logic [1:0]               m_write_status,
    output logic [ADDR_W-1:0]        m_pixel_address,
    output logic [PIXEL_W-1:0]       m_pixel_value
);

    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    logic [CFG_W-1:0]   width_eff;
    logic [CFG_W-1:0]   height_eff;

    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;
    logic [PIXEL_W-1:0] col_reg;

    logic [COORD_W:0]   row;
    logic               x_ok;
    logic               row_ok;
    logic [Y_IDX_W+CFG_W-1:0] row_prod;
    logic [ADDR_W-1:0]  addr_next;
    logic [ADDR_W-1:0]  addr_reg;
    logic               clip_reg;

    logic [PIXEL_W-1:0] mem [STORE_DEPTH];
    logic [PIXEL_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]  clr_addr_reg;

    logic [7:0]         src_a;
    logic [7:0]         inv_a;
    logic [15:0]        r_sum_next;
    logic [15:0]        g_sum_next;
    logic [15:0]        b_sum_next;
    logic [15:0]        r_sum_reg;
    logic [15:0]        g_sum_reg;
    logic [15:0]        b_sum_reg;
    logic [7:0]         oa_reg;
    logic [PIXEL_W-1:0] dst_reg;

    logic [PIXEL_W-1:0] res_value;
    write_status_t      res_status;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [PIXEL_W-1:0] mem_wdata;

    logic [1:0]         out_status_reg;
    logic [ADDR_W-1:0]  out_addr_reg;
    logic [PIXEL_W-1:0] out_value_reg;

    // config registers, saturated to the store size
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  width_reg  <= cfg_wdata;
                REG_SCREEN_HEIGHT: height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign width_eff  = (width_reg > WIDTH_LIMIT) ? WIDTH_LIMIT : width_reg;
    assign height_eff = (height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_reg;

    // request capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg   <= s_pos_x;
            y_reg   <= s_pos_y;
            col_reg <= s_src_colour;
        end
    end

    // row flip, clipping and address
    assign row      = {{(COORD_W-CFG_W+1){1'b0}}, height_eff} - {y_reg[COORD_W-1], y_reg};
    assign x_ok     = !x_reg[COORD_W-1]
                      && (x_reg[COORD_W-2:0] < {{(COORD_W-1-CFG_W){1'b0}}, width_eff});
    assign row_ok   = !row[COORD_W]
                      && (row[COORD_W-1:0] < {{(COORD_W-CFG_W){1'b0}}, height_eff});
    assign row_prod = {{CFG_W{1'b0}}, row[Y_IDX_W-1:0]} * {{Y_IDX_W{1'b0}}, width_eff};
    assign addr_next = row_prod[ADDR_W-1:0] + {{(ADDR_W-X_IDX_W){1'b0}}, x_reg[X_IDX_W-1:0]};

    always_ff @(posedge aclk) begin
        if (cmd.calc) begin
            addr_reg <= (x_ok && row_ok) ? addr_next : '0;
            clip_reg <= !(x_ok && row_ok);
        end
    end

    // products of the blend, registered before the divide
    assign src_a = col_reg[31:24];
    assign inv_a = ALPHA_OPAQUE - src_a;
    assign r_sum_next = (16'(col_reg[23:16]) * 16'(src_a)) + (16'(rd_data_reg[23:16]) * 16'(inv_a));
    assign g_sum_next = (16'(col_reg[15:8]) * 16'(src_a)) + (16'(rd_data_reg[15:8]) * 16'(inv_a));
    assign b_sum_next = (16'(col_reg[7:0]) * 16'(src_a)) + (16'(rd_data_reg[7:0]) * 16'(inv_a));

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            r_sum_reg <= r_sum_next;
            g_sum_reg <= g_sum_next;
            b_sum_reg <= b_sum_next;
            oa_reg    <= (src_a > rd_data_reg[31:24]) ? src_a : rd_data_reg[31:24];
            dst_reg   <= rd_data_reg;
        end
    end

    always_comb begin
        if (clip_reg) begin
            res_status = WS_CLIPPED;
            res_value  = '0;
        end else if (src_a == ALPHA_OPAQUE) begin
            res_status = WS_OPAQUE;
            res_value  = col_reg;
        end else if (src_a == ALPHA_CLEAR) begin
            res_status = WS_TRANSPARENT;
            res_value  = dst_reg;
        end else begin
            res_status = WS_BLENDED;
            res_value  = {oa_reg, div255(r_sum_reg), div255(g_sum_reg), div255(b_sum_reg)};
        end
    end

    // frame store with clearing sweep after reset
    assign mem_we    = cmd.clear || (cmd.write && !clip_reg);
    assign mem_waddr = cmd.clear ? clr_addr_reg : addr_reg;
    assign mem_wdata = cmd.clear ? '0 : res_value;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clear) begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
        end
    end

    assign status.clear_last = (clr_addr_reg == ADDR_W'(STORE_DEPTH - 1));
    assign status.clip       = clip_reg;

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.write) begin
            out_status_reg <= res_status;
            out_addr_reg   <= addr_reg;
            out_value_reg  <= res_value;
        end
    end

    assign m_write_status  = out_status_reg;
    assign m_pixel_address = out_addr_reg;
    assign m_pixel_value   = out_value_reg;

endmodule

### hw/rtl/abpw_ctrl.sv
// controller: clearing sweep, request sequencing and result handshake
module abpw_ctrl
    import abpw_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    typedef enum logic [2:0] {
        CLEAR,
        IDLE,
        CALC,
        READ,
        MUL,
        WRITE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            CLEAR: begin
                cmd.clear = 1'b1;
                if (status.clear_last) begin
                    state_next = IDLE;
                end
            end
            IDLE: begin
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = CALC;
                end
            end
            CALC: begin
                cmd.calc   = 1'b1;
                state_next = READ;
            end
            READ: begin
                // a clipped request skips the blend
                state_next = status.clip ? WRITE : MUL;
            end
            MUL: begin
                cmd.mul    = 1'b1;
                state_next = WRITE;
            end
            WRITE: begin
                if (out_free) begin
                    cmd.write    = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == IDLE);
    assign m_valid = m_valid_reg;

`ifndef ASSERT_OFF
    a_no_result_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == CLEAR) |-> !m_valid_reg)
        else $error("result valid during clearing sweep");

    a_result_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.write |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten while occupied");

    a_accept_starts_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == CALC))
        else $error("accepted request did not start address calculation");

    a_clip_skips_blend: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == READ && status.clip) |=> (state_reg == WRITE))
        else $error("clipped request entered the blend stage");
`endif

endmodule
